/* src/cft_pkg.sv */
package cft_pkg;

	localparam int MAX_SEGMENTS = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int TABLE_LEN = 24;

	// cordic datapath width, q30 with headroom
	localparam int CW = 34;
	// segment count and rim point index, 0 .. MAX_SEGMENTS + 1
	localparam int SEG_W = $clog2(MAX_SEGMENTS + 2);
	localparam int STEP_W = $clog2(TABLE_LEN);

	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic [16:0] TURN_TO_RAD = 17'd102944;
	localparam logic signed [15:0] CFG_RESET = 16'sd256;

	// register indexes on the apb port
	localparam logic [1:0] REG_CONE_HEIGHT = 2'd0;
	localparam logic [1:0] REG_TOP_RADIUS = 2'd1;
	localparam logic [1:0] REG_BOTTOM_RADIUS = 2'd2;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} vtx_t;

	typedef struct packed {
		logic [16:0] quo;
		logic [4:0] rem;
	} angle_step_t;

	typedef enum logic [1:0] {
		MODE_TOP_APEX,
		MODE_BOT_APEX,
		MODE_FRUSTUM
	} mode_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ANGLE,
		S_CORDIC,
		S_SCALE,
		S_EMIT,
		S_NEXT
	} state_t;

	typedef enum logic [1:0] {
		C_IDLE,
		C_ROT,
		C_MAP
	} cordic_state_t;

	function automatic logic signed [CW-1:0] atan_q30(input logic [STEP_W-1:0] k);
		logic signed [CW-1:0] v;
		case (k)
			5'd0: v = 34'sd843314857;
			5'd1: v = 34'sd497837829;
			5'd2: v = 34'sd263043837;
			5'd3: v = 34'sd133525159;
			5'd4: v = 34'sd67021687;
			5'd5: v = 34'sd33543516;
			5'd6: v = 34'sd16775851;
			5'd7: v = 34'sd8388437;
			5'd8: v = 34'sd4194283;
			5'd9: v = 34'sd2097149;
			5'd10: v = 34'sd1048576;
			5'd11: v = 34'sd524288;
			5'd12: v = 34'sd262144;
			5'd13: v = 34'sd131072;
			5'd14: v = 34'sd65536;
			5'd15: v = 34'sd32768;
			5'd16: v = 34'sd16384;
			5'd17: v = 34'sd8192;
			5'd18: v = 34'sd4096;
			5'd19: v = 34'sd2048;
			5'd20: v = 34'sd1024;
			5'd21: v = 34'sd512;
			5'd22: v = 34'sd256;
			5'd23: v = 34'sd128;
			default: v = '0;
		endcase
		return v;
	endfunction

	// 65536 / n as quotient and remainder, n = 1 .. 16
	function automatic angle_step_t angle_step(input logic [SEG_W-1:0] n);
		angle_step_t s;
		case (n)
			5'd1: s = '{quo: 17'd65536, rem: 5'd0};
			5'd2: s = '{quo: 17'd32768, rem: 5'd0};
			5'd3: s = '{quo: 17'd21845, rem: 5'd1};
			5'd4: s = '{quo: 17'd16384, rem: 5'd0};
			5'd5: s = '{quo: 17'd13107, rem: 5'd1};
			5'd6: s = '{quo: 17'd10922, rem: 5'd4};
			5'd7: s = '{quo: 17'd9362, rem: 5'd2};
			5'd8: s = '{quo: 17'd8192, rem: 5'd0};
			5'd9: s = '{quo: 17'd7281, rem: 5'd7};
			5'd10: s = '{quo: 17'd6553, rem: 5'd6};
			5'd11: s = '{quo: 17'd5957, rem: 5'd9};
			5'd12: s = '{quo: 17'd5461, rem: 5'd4};
			5'd13: s = '{quo: 17'd5041, rem: 5'd3};
			5'd14: s = '{quo: 17'd4681, rem: 5'd2};
			5'd15: s = '{quo: 17'd4369, rem: 5'd1};
			5'd16: s = '{quo: 17'd4096, rem: 5'd0};
			default: s = '{quo: 17'd0, rem: 5'd0};
		endcase
		return s;
	endfunction

endpackage

/* src/cone_frustum_tessellator_unit.sv */
// cone / frustum tessellator
// config: apb port, cone_height at 0x0, top_radius at 0x4, bottom_radius at 0x8
// (signed q8.8 in the low 16 bits, reset 256 each); write only while idle.
// input: one beat of segments_requested per mesh (negative means 16, capped
// at 16, zero gives no triangles). in_ready is high only while idle.
// output: one beat per triangle, three q8.8 vertices, triangle_number and
// last_triangle on the final beat; 2*n triangles when one radius is not
// positive, 4*n otherwise.
// sequencing: n+1 rim points run one after another through one iterative cordic
// and one shared 16x32 multiplier (4 products); the triangles a point closes
// leave one per cycle while the receiver is ready. a stalled receiver holds
// the output register and the sequencer waits on it; nothing is dropped.
// reset returns the block to idle with the registers at their reset values
// and no output pending.
module cone_frustum_tessellator_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [5:0]  segments_requested,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] vertex_a_x,
	output logic signed [15:0] vertex_a_y,
	output logic signed [15:0] vertex_a_z,
	output logic signed [15:0] vertex_b_x,
	output logic signed [15:0] vertex_b_y,
	output logic signed [15:0] vertex_b_z,
	output logic signed [15:0] vertex_c_x,
	output logic signed [15:0] vertex_c_y,
	output logic signed [15:0] vertex_c_z,
	output logic [5:0]         triangle_number,
	output logic               last_triangle
);

	localparam int SW = cft_pkg::SEG_W;

	logic signed [15:0] cone_height_q, top_radius_q, bottom_radius_q;
	logic cfg_write;

	cft_pkg::state_t state_q, state_d;
	cft_pkg::mode_t mode_q, mode_in;
	logic [SW-1:0] n_q, n_in, pt_q;
	logic [16:0] t_q;
	logic [4:0] rem_q, rem_sum;
	logic wrap;
	cft_pkg::angle_step_t step;
	logic signed [15:0] h_q, rt_q, rb_q, nh;
	logic [5:0] k_q;
	logic [1:0] ti_q, ti_last;
	logic [2:0] mcnt_q;

	logic cordic_start, cordic_done;
	logic signed [cft_pkg::CW-1:0] cos_w, sin_w;

	logic signed [15:0] mul_r;
	logic signed [31:0] mul_c;
	logic signed [47:0] prod_s1, rnd;
	logic signed [15:0] sat;

	logic signed [15:0] cur_tx_q, cur_ty_q, cur_bx_q, cur_by_q;
	logic signed [15:0] prv_tx_q, prv_ty_q, prv_bx_q, prv_by_q;

	cft_pkg::vtx_t ct, cb, tp, tc, bp, bc, tri_a, tri_b, tri_c;
	cft_pkg::vtx_t out_a_q, out_b_q, out_c_q;
	logic [5:0] num_q;
	logic last_q, out_valid_q;

	logic accept, out_free, emit_fire, last_tri;

	// configuration port
	assign pready = 1'b1;
	assign cfg_write = psel & penable & pwrite;

	always_comb begin
		unique case (paddr[3:2])
			cft_pkg::REG_CONE_HEIGHT: prdata = {16'b0, cone_height_q};
			cft_pkg::REG_TOP_RADIUS: prdata = {16'b0, top_radius_q};
			cft_pkg::REG_BOTTOM_RADIUS: prdata = {16'b0, bottom_radius_q};
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cone_height_q <= cft_pkg::CFG_RESET;
			top_radius_q <= cft_pkg::CFG_RESET;
			bottom_radius_q <= cft_pkg::CFG_RESET;
		end else if (cfg_write) begin
			unique case (paddr[3:2])
				cft_pkg::REG_CONE_HEIGHT: cone_height_q <= pwdata[15:0];
				cft_pkg::REG_TOP_RADIUS: top_radius_q <= pwdata[15:0];
				cft_pkg::REG_BOTTOM_RADIUS: bottom_radius_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// request decode
	always_comb begin
		if (segments_requested[5]) begin
			n_in = SW'(cft_pkg::MAX_SEGMENTS);
		end else if (int'(segments_requested[4:0]) > cft_pkg::MAX_SEGMENTS) begin
			n_in = SW'(cft_pkg::MAX_SEGMENTS);
		end else begin
			n_in = SW'(segments_requested[4:0]);
		end
		if (top_radius_q[15] || top_radius_q == 16'sd0) begin
			mode_in = cft_pkg::MODE_TOP_APEX;
		end else if (bottom_radius_q[15] || bottom_radius_q == 16'sd0) begin
			mode_in = cft_pkg::MODE_BOT_APEX;
		end else begin
			mode_in = cft_pkg::MODE_FRUSTUM;
		end
	end

	// angle walks by 65536/n with the remainder carried along
	assign step = cft_pkg::angle_step(n_q);
	assign rem_sum = rem_q + step.rem;
	assign wrap = (rem_sum >= 5'(n_q));

	cft_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cordic_start),
		.angle   (t_q[15:0]),
		.done    (cordic_done),
		.cos_out (cos_w),
		.sin_out (sin_w)
	);

	// shared multiplier: rt*cos, rt*sin, rb*cos, rb*sin
	always_comb begin
		case (mcnt_q[1:0])
			2'd0: begin
				mul_r = rt_q;
				mul_c = cos_w[31:0];
			end
			2'd1: begin
				mul_r = rt_q;
				mul_c = sin_w[31:0];
			end
			2'd2: begin
				mul_r = rb_q;
				mul_c = cos_w[31:0];
			end
			default: begin
				mul_r = rb_q;
				mul_c = sin_w[31:0];
			end
		endcase
		rnd = (prod_s1 + 48'sd536870912) >>> 30;
		if (rnd > 48'sd32767) begin
			sat = 16'sd32767;
		end else if (rnd < -48'sd32768) begin
			sat = -16'sd32768;
		end else begin
			sat = rnd[15:0];
		end
	end

	// triangle select
	always_comb begin
		nh = -h_q;
		ct = '{x: 16'sd0, y: 16'sd0, z: h_q};
		cb = '{x: 16'sd0, y: 16'sd0, z: nh};
		tp = '{x: prv_tx_q, y: prv_ty_q, z: h_q};
		tc = '{x: cur_tx_q, y: cur_ty_q, z: h_q};
		bp = '{x: prv_bx_q, y: prv_by_q, z: nh};
		bc = '{x: cur_bx_q, y: cur_by_q, z: nh};
		ti_last = (mode_q == cft_pkg::MODE_FRUSTUM) ? 2'd3 : 2'd1;
		tri_a = bp;
		tri_b = cb;
		tri_c = bc;
		case (mode_q)
			cft_pkg::MODE_TOP_APEX: begin
				if (ti_q == 2'd0) begin
					tri_a = ct;
					tri_b = bp;
					tri_c = bc;
				end
			end
			cft_pkg::MODE_BOT_APEX: begin
				if (ti_q == 2'd0) begin
					tri_a = tp;
					tri_b = cb;
					tri_c = tc;
				end else begin
					tri_a = tp;
					tri_b = tc;
					tri_c = ct;
				end
			end
			default: begin
				case (ti_q)
					2'd0: begin
						tri_a = tp;
						tri_b = bp;
						tri_c = bc;
					end
					2'd1: begin
						tri_a = tp;
						tri_b = bc;
						tri_c = tc;
					end
					2'd2: begin
						tri_a = tp;
						tri_b = tc;
						tri_c = ct;
					end
					default: begin
						tri_a = bp;
						tri_b = cb;
						tri_c = bc;
					end
				endcase
			end
		endcase
	end

	// sequencer
	assign in_ready = (state_q == cft_pkg::S_IDLE);
	assign accept = in_valid & in_ready;
	assign out_free = ~out_valid_q | out_ready;
	assign emit_fire = (state_q == cft_pkg::S_EMIT) & out_free;
	assign cordic_start = (state_q == cft_pkg::S_ANGLE);
	assign last_tri = (pt_q == n_q) && (ti_q == ti_last);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cft_pkg::S_IDLE: begin
				if (accept && n_in != '0) state_d = cft_pkg::S_ANGLE;
			end
			cft_pkg::S_ANGLE: state_d = cft_pkg::S_CORDIC;
			cft_pkg::S_CORDIC: begin
				if (cordic_done) state_d = cft_pkg::S_SCALE;
			end
			cft_pkg::S_SCALE: begin
				if (mcnt_q == 3'd4) begin
					// the first rim point only seeds the previous point
					state_d = (pt_q == '0) ? cft_pkg::S_NEXT : cft_pkg::S_EMIT;
				end
			end
			cft_pkg::S_EMIT: begin
				if (out_free && ti_q == ti_last) state_d = cft_pkg::S_NEXT;
			end
			cft_pkg::S_NEXT: begin
				state_d = (pt_q == n_q) ? cft_pkg::S_IDLE : cft_pkg::S_ANGLE;
			end
			default: state_d = cft_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cft_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			n_q <= n_in;
			mode_q <= mode_in;
			h_q <= cone_height_q >>> 1;
			rt_q <= top_radius_q;
			rb_q <= bottom_radius_q;
			pt_q <= '0;
			t_q <= '0;
			rem_q <= '0;
			k_q <= '0;
		end
		if (state_q == cft_pkg::S_ANGLE) begin
			mcnt_q <= '0;
		end
		if (state_q == cft_pkg::S_SCALE) begin
			ti_q <= '0;
			mcnt_q <= mcnt_q + 1'b1;
			if (mcnt_q != 3'd4) begin
				prod_s1 <= mul_r * mul_c;
			end
			case (mcnt_q)
				3'd1: cur_tx_q <= sat;
				3'd2: cur_ty_q <= sat;
				3'd3: cur_bx_q <= sat;
				3'd4: cur_by_q <= sat;
				default: ;
			endcase
		end
		if (emit_fire) begin
			out_a_q <= tri_a;
			out_b_q <= tri_b;
			out_c_q <= tri_c;
			num_q <= k_q;
			last_q <= last_tri;
			k_q <= k_q + 1'b1;
			ti_q <= ti_q + 1'b1;
		end
		if (state_q == cft_pkg::S_NEXT) begin
			prv_tx_q <= cur_tx_q;
			prv_ty_q <= cur_ty_q;
			prv_bx_q <= cur_bx_q;
			prv_by_q <= cur_by_q;
			pt_q <= pt_q + 1'b1;
			t_q <= t_q + step.quo + 17'(wrap);
			rem_q <= wrap ? (rem_sum - 5'(n_q)) : rem_sum;
		end
	end

	assign out_valid = out_valid_q;
	assign vertex_a_x = out_a_q.x;
	assign vertex_a_y = out_a_q.y;
	assign vertex_a_z = out_a_q.z;
	assign vertex_b_x = out_b_q.x;
	assign vertex_b_y = out_b_q.y;
	assign vertex_b_z = out_b_q.z;
	assign vertex_c_x = out_c_q.x;
	assign vertex_c_y = out_c_q.y;
	assign vertex_c_z = out_c_q.z;
	assign triangle_number = num_q;
	assign last_triangle = last_q;

endmodule

/* src/cft_cordic.sv */
module cft_cordic (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [15:0]                        angle,
	output logic                               done,
	output logic signed [cft_pkg::CW-1:0]      cos_out,
	output logic signed [cft_pkg::CW-1:0]      sin_out
);

	cft_pkg::cordic_state_t state_q, state_d;
	logic [cft_pkg::STEP_W-1:0] step_q;
	logic [1:0] quad_q;
	logic signed [cft_pkg::CW-1:0] x_q, y_q, z_q;
	logic signed [cft_pkg::CW-1:0] cos_q, sin_q;
	logic signed [cft_pkg::CW-1:0] xs, ys, atan_k, x_n, y_n, z_n;
	logic [30:0] z_init;
	logic step_last;
	logic done_q;

	assign step_last = (step_q == cft_pkg::STEP_W'(cft_pkg::CORDIC_STEPS - 1));
	assign z_init = 31'(angle[13:0]) * 31'(cft_pkg::TURN_TO_RAD);

	// one rotation step per cycle through a shared shifter and adders
	always_comb begin
		xs = x_q >>> step_q;
		ys = y_q >>> step_q;
		atan_k = cft_pkg::atan_q30(step_q);
		if (!z_q[cft_pkg::CW-1]) begin
			x_n = x_q - ys;
			y_n = y_q + xs;
			z_n = z_q - atan_k;
		end else begin
			x_n = x_q + ys;
			y_n = y_q - xs;
			z_n = z_q + atan_k;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cft_pkg::C_IDLE: begin
				if (start) state_d = cft_pkg::C_ROT;
			end
			cft_pkg::C_ROT: begin
				if (step_last) state_d = cft_pkg::C_MAP;
			end
			cft_pkg::C_MAP: state_d = cft_pkg::C_IDLE;
			default: state_d = cft_pkg::C_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cft_pkg::C_IDLE;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (state_q == cft_pkg::C_MAP);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == cft_pkg::C_IDLE && start) begin
			quad_q <= angle[15:14];
			z_q <= cft_pkg::CW'(z_init);
			x_q <= cft_pkg::CORDIC_GAIN;
			y_q <= '0;
			step_q <= '0;
		end else if (state_q == cft_pkg::C_ROT) begin
			x_q <= x_n;
			y_q <= y_n;
			z_q <= z_n;
			step_q <= step_q + 1'b1;
		end
		if (state_q == cft_pkg::C_MAP) begin
			// fold the first-quadrant result into the full turn
			case (quad_q)
				2'd0: begin
					cos_q <= x_q;
					sin_q <= y_q;
				end
				2'd1: begin
					cos_q <= -y_q;
					sin_q <= x_q;
				end
				2'd2: begin
					cos_q <= -x_q;
					sin_q <= -y_q;
				end
				default: begin
					cos_q <= y_q;
					sin_q <= -x_q;
				end
			endcase
		end
	end

	assign done = done_q;
	assign cos_out = cos_q;
	assign sin_out = sin_q;

endmodule

/* src/cft_checker.sv */
module cft_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               pready,
	input logic               in_valid,
	input logic               in_ready,
	input logic signed [5:0]  segments_requested,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] vertex_a_x,
	input logic [5:0]         triangle_number,
	input logic               last_triangle
);

	// a nonzero request leaves the block busy in the cycle after it is taken
	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && segments_requested != 6'sd0) |=> !in_ready)
		else $error("in_ready stayed high after a nonzero request");

	// more triangles pending means no new request is taken
	a_busy_mid_mesh: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_triangle) |=> !in_ready)
		else $error("block went idle before the last triangle");

	// every mesh has an even triangle count
	a_last_odd: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_triangle) |-> triangle_number[0])
		else $error("last triangle has an even number");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
		(out_valid && $stable(vertex_a_x) && $stable(triangle_number)))
		else $error("output beat changed while stalled");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind cone_frustum_tessellator_unit cft_checker u_cft_checker (.*);

/* sim/mesh_checker.sv */
module mesh_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [5:0]  segments_requested,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [15:0] vertex_a_x,
	input  logic signed [15:0] vertex_a_y,
	input  logic signed [15:0] vertex_a_z,
	input  logic signed [15:0] vertex_b_x,
	input  logic signed [15:0] vertex_b_y,
	input  logic signed [15:0] vertex_b_z,
	input  logic signed [15:0] vertex_c_x,
	input  logic signed [15:0] vertex_c_y,
	input  logic signed [15:0] vertex_c_z,
	input  logic [5:0]         triangle_number,
	input  logic               last_triangle,
	output int                 fail_count,
	output int                 pending,
	output int                 triangles_checked
);

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		cft_pkg::vtx_t a;
		cft_pkg::vtx_t b;
		cft_pkg::vtx_t c;
		logic [5:0] num;
		logic last;
	} triangle_t;

	localparam longint ARCTAN_Q30 [cft_pkg::TABLE_LEN] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
		65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128
	};

	string field_label [11] = '{
		"vertex_a_x", "vertex_a_y", "vertex_a_z", "vertex_b_x", "vertex_b_y",
		"vertex_b_z", "vertex_c_x", "vertex_c_y", "vertex_c_z", "triangle_number",
		"last_triangle"
	};

	logic signed [15:0] height_q, top_q, bot_q;
	triangle_t mesh_q [$];
	triangle_t seen, want;
	int fld;

	initial begin
		fail_count = 0;
		triangles_checked = 0;
		pending = 0;
	end

	task automatic report_error(input string msg);
		$display("mesh_checker: %s", msg);
		fail_count++;
	endtask

	// cosine and sine in q30 for an angle in 2^-16 turns
	function automatic void rim_angle(input logic [15:0] turn, output longint co,
			output longint si);
		longint x, y, z, nx;
		int k;
		z = longint'(turn[13:0]) * longint'(cft_pkg::TURN_TO_RAD);
		x = longint'(cft_pkg::CORDIC_GAIN);
		y = 0;
		for (k = 0; k < cft_pkg::CORDIC_STEPS && k < cft_pkg::TABLE_LEN; k++) begin
			if (z >= 0) begin
				nx = x - (y >>> k);
				y = y + (x >>> k);
				z = z - ARCTAN_Q30[k];
			end else begin
				nx = x + (y >>> k);
				y = y - (x >>> k);
				z = z + ARCTAN_Q30[k];
			end
			x = nx;
		end
		case (turn[15:14])
			2'd0: begin co = x; si = y; end
			2'd1: begin co = -y; si = x; end
			2'd2: begin co = -x; si = -y; end
			default: begin co = y; si = -x; end
		endcase
	endfunction

	function automatic logic signed [15:0] rim_coord(input int radius, input longint trig);
		longint v;
		v = (longint'(radius) * trig + (longint'(1) << 29)) >>> 30;
		if (v > 32767)
			v = 32767;
		else if (v < -32768)
			v = -32768;
		return v[15:0];
	endfunction

	task automatic add_triangle(input cft_pkg::vtx_t a, input cft_pkg::vtx_t b,
			input cft_pkg::vtx_t c, input int num, input int total);
		triangle_t t;
		t.a = a;
		t.b = b;
		t.c = c;
		t.num = num[5:0];
		t.last = (num == total - 1);
		mesh_q.push_back(t);
	endtask

	task automatic predict_mesh(input logic [5:0] raw);
		int n, h, rt, rb, total, i;
		longint co, si;
		logic [15:0] turn;
		cft_pkg::vtx_t top_pt [cft_pkg::MAX_SEGMENTS+1];
		cft_pkg::vtx_t bot_pt [cft_pkg::MAX_SEGMENTS+1];
		cft_pkg::vtx_t apex_top, apex_bot;
		n = raw[5] ? 16 : int'(raw);
		if (n > cft_pkg::MAX_SEGMENTS)
			n = cft_pkg::MAX_SEGMENTS;
		if (n <= 0)
			return;
		h = int'(height_q) >>> 1;
		rt = int'(top_q);
		rb = int'(bot_q);
		apex_top = '{x: 16'sd0, y: 16'sd0, z: 16'(h)};
		apex_bot = '{x: 16'sd0, y: 16'sd0, z: 16'(-h)};
		for (i = 0; i <= n; i++) begin
			turn = 16'((i * 65536) / n);
			rim_angle(turn, co, si);
			top_pt[i] = '{x: rim_coord(rt, co), y: rim_coord(rt, si), z: 16'(h)};
			bot_pt[i] = '{x: rim_coord(rb, co), y: rim_coord(rb, si), z: 16'(-h)};
		end
		if (rt <= 0) begin
			total = 2 * n;
			for (i = 0; i < n; i++) begin
				add_triangle(apex_top, bot_pt[i], bot_pt[i+1], 2 * i, total);
				add_triangle(bot_pt[i], apex_bot, bot_pt[i+1], 2 * i + 1, total);
			end
		end else if (rb <= 0) begin
			total = 2 * n;
			for (i = 0; i < n; i++) begin
				add_triangle(top_pt[i], apex_bot, top_pt[i+1], 2 * i, total);
				add_triangle(top_pt[i], top_pt[i+1], apex_top, 2 * i + 1, total);
			end
		end else begin
			total = 4 * n;
			for (i = 0; i < n; i++) begin
				add_triangle(top_pt[i], bot_pt[i], bot_pt[i+1], 4 * i, total);
				add_triangle(top_pt[i], bot_pt[i+1], top_pt[i+1], 4 * i + 1, total);
				add_triangle(top_pt[i], top_pt[i+1], apex_top, 4 * i + 2, total);
				add_triangle(bot_pt[i], apex_bot, bot_pt[i+1], 4 * i + 3, total);
			end
		end
	endtask

	function automatic int field_of(input triangle_t t, input int idx);
		case (idx)
			0: return t.a.x;
			1: return t.a.y;
			2: return t.a.z;
			3: return t.b.x;
			4: return t.b.y;
			5: return t.b.z;
			6: return t.c.x;
			7: return t.c.y;
			8: return t.c.z;
			9: return int'(t.num);
			default: return int'(t.last);
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q = cft_pkg::CFG_RESET;
			top_q = cft_pkg::CFG_RESET;
			bot_q = cft_pkg::CFG_RESET;
			mesh_q.delete();
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					cft_pkg::REG_CONE_HEIGHT: height_q = pwdata[15:0];
					cft_pkg::REG_TOP_RADIUS: top_q = pwdata[15:0];
					cft_pkg::REG_BOTTOM_RADIUS: bot_q = pwdata[15:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				predict_mesh(segments_requested);
			if (out_valid && out_ready) begin
				seen = {vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y,
					vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z, triangle_number,
					last_triangle};
				triangles_checked++;
				if (mesh_q.size() == 0) begin
					report_error($sformatf("triangle %0d arrived with none expected",
						triangle_number));
				end else begin
					want = mesh_q.pop_front();
					for (fld = 0; fld < 11; fld++) begin
						if (field_of(seen, fld) != field_of(want, fld))
							report_error($sformatf("triangle %0d %s: got %0d, expected %0d",
								want.num, field_label[fld], field_of(seen, fld),
								field_of(want, fld)));
					end
				end
			end
			pending <= mesh_q.size();
		end
	end

endmodule

/* sim/tb_top.sv */
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 4000;
	// quiet gap before a new shape is loaded
	localparam int HOLD_OFF = 500;
	localparam int DRAIN = 600;
	localparam int RANDOM_SHAPES = 8;
	localparam int REQUESTS_PER_SHAPE = 15;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [3:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid;
	logic               in_ready;
	logic signed [5:0]  segments_requested;
	logic               out_valid;
	logic               out_ready;
	logic signed [15:0] vertex_a_x, vertex_a_y, vertex_a_z;
	logic signed [15:0] vertex_b_x, vertex_b_y, vertex_b_z;
	logic signed [15:0] vertex_c_x, vertex_c_y, vertex_c_z;
	logic [5:0]         triangle_number;
	logic               last_triangle;

	int fail_count, pending, triangles_checked;
	int quiet_cycles;
	int requests_sent;
	int shapes_run;
	bit calm;

	cone_frustum_tessellator_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .segments_requested(segments_requested),
		.out_valid(out_valid), .out_ready(out_ready),
		.vertex_a_x(vertex_a_x), .vertex_a_y(vertex_a_y), .vertex_a_z(vertex_a_z),
		.vertex_b_x(vertex_b_x), .vertex_b_y(vertex_b_y), .vertex_b_z(vertex_b_z),
		.vertex_c_x(vertex_c_x), .vertex_c_y(vertex_c_y), .vertex_c_z(vertex_c_z),
		.triangle_number(triangle_number), .last_triangle(last_triangle)
	);

	mesh_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .segments_requested(segments_requested),
		.out_valid(out_valid), .out_ready(out_ready),
		.vertex_a_x(vertex_a_x), .vertex_a_y(vertex_a_y), .vertex_a_z(vertex_a_z),
		.vertex_b_x(vertex_b_x), .vertex_b_y(vertex_b_y), .vertex_b_z(vertex_b_z),
		.vertex_c_x(vertex_c_x), .vertex_c_y(vertex_c_y), .vertex_c_z(vertex_c_z),
		.triangle_number(triangle_number), .last_triangle(last_triangle),
		.fail_count(fail_count), .pending(pending), .triangles_checked(triangles_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver side: random stall bursts, none once calm
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (calm) begin
				out_ready <= 1'b1;
				@(posedge clk);
			end else begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				out_ready <= 1'b1;
				if ($urandom_range(0, 5) == 0)
					repeat (80) @(posedge clk);
				else
					repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pwrite)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_top: no beat for %0d cycles", WATCHDOG_LIMIT);
				$display("tb_top: done, errors");
				$finish;
			end
		end
	end

	task automatic reg_write(input logic [1:0] idx, input logic [15:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// wait until the block has drained, then load a new shape
	task automatic set_shape(input logic [15:0] height, input logic [15:0] top_r,
			input logic [15:0] bot_r);
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (HOLD_OFF) @(posedge clk);
		while (!in_ready) @(posedge clk);
		reg_write(cft_pkg::REG_CONE_HEIGHT, height);
		reg_write(cft_pkg::REG_TOP_RADIUS, top_r);
		reg_write(cft_pkg::REG_BOTTOM_RADIUS, bot_r);
		shapes_run++;
	endtask

	task automatic send_request(input logic [5:0] count);
		if (!calm && $urandom_range(0, 2) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1'b1;
		segments_requested <= count;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		requests_sent++;
	endtask

	function automatic logic [5:0] pick_count();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return 6'($urandom_range(1, 6));
			6, 7: return 6'($urandom_range(7, 16));
			8: return 6'($urandom_range(17, 31));
			default: return ($urandom_range(0, 1) == 0) ? 6'd0 : (6'h20 | 6'($urandom));
		endcase
	endfunction

	function automatic logic [15:0] pick_radius(input bit positive);
		case ($urandom_range(0, 3))
			0: return positive ? 16'h7FFF : 16'h8000;
			1: return positive ? 16'd1 : 16'd0;
			2: return positive ? 16'($urandom_range(1, 2048)) : 16'(-$urandom_range(1, 2048));
			default: return positive ? 16'($urandom_range(1, 32767))
				: 16'($urandom_range(32768, 65535));
		endcase
	endfunction

	function automatic logic [15:0] pick_height();
		case ($urandom_range(0, 4))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'($urandom_range(0, 1024));
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		logic [5:0] directed_counts [$];
		int s, r, kind;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		segments_requested = '0;
		calm = 1'b0;
		quiet_cycles = 0;
		requests_sent = 0;
		shapes_run = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset shape is a frustum; default, zero, smallest, saturated counts
		directed_counts = '{6'h3F, 6'd0, 6'd1, 6'd2, 6'd3, 6'd16, 6'd31, 6'h20, 6'd17};
		foreach (directed_counts[i])
			send_request(directed_counts[i]);
		in_valid <= 1'b0;

		set_shape(16'd256, 16'd0, 16'd384);
		send_request(6'd4);
		in_valid <= 1'b0;
		set_shape(16'd512, 16'd200, 16'd0);
		send_request(6'd4);
		in_valid <= 1'b0;
		// both radii not positive: apex at top, negative bottom used as given
		set_shape(16'd300, 16'hFF00, 16'hFE00);
		send_request(6'd3);
		in_valid <= 1'b0;
		set_shape(16'h8000, 16'h7FFF, 16'h7FFF);
		send_request(6'd16);
		in_valid <= 1'b0;
		set_shape(16'h7FFF, 16'h8000, 16'h8000);
		send_request(6'd5);
		in_valid <= 1'b0;
		set_shape(16'hFFFF, 16'd1, 16'h8000);
		send_request(6'd7);
		in_valid <= 1'b0;

		for (s = 0; s < RANDOM_SHAPES; s++) begin
			kind = $urandom_range(0, 5);
			set_shape(pick_height(), pick_radius(kind >= 2),
				pick_radius(kind != 1 && kind != 2));
			if (s == RANDOM_SHAPES - 1)
				calm = 1'b1;
			for (r = 0; r < REQUESTS_PER_SHAPE; r++)
				send_request(pick_count());
			in_valid <= 1'b0;
		end

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		$display("tb_top: %0d requests over %0d loaded shapes plus the reset shape",
			requests_sent, shapes_run);
		$display("tb_top: %0d triangles compared, %0d mismatches", triangles_checked,
			fail_count);
		if (fail_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

/* cone_frustum_tessellator_unit.f */
src/cft_pkg.sv
src/cft_cordic.sv
src/cone_frustum_tessellator_unit.sv
src/cft_checker.sv
sim/mesh_checker.sv
sim/tb_top.sv
